// File: hw/rtl/slot_timer_table_defines.svh
// Assertion macros for the slot timer table.
// Each macro expects signals named clock and reset in the including scope.
`ifndef SLOT_TIMER_TABLE_DEFINES_SVH
`define SLOT_TIMER_TABLE_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define STT_ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`define STT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`define STT_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error(msg);

`else

`define STT_ASSERT_IMPLIES(label, ante, cons, msg)

`define STT_ASSERT_NEXT(label, ante, cons, msg)

`define STT_ASSERT_ALWAYS(label, cond, msg)

`endif

`endif

// File: hw/rtl/stt_pkg.sv
// Shared types, codes and sizing functions for the slot timer table.
// No dependencies.
`timescale 1ns / 1ps

package stt_pkg;

   localparam int unsigned NumSlotsDefault = 16;
   localparam int unsigned TagBitsDefault  = 8;
   localparam int unsigned MaxSlots        = 16;
   localparam int unsigned TIME_W          = 32;

   typedef enum logic [1:0] {
      REQ_TICK     = 2'd0,
      REQ_ONE_SHOT = 2'd1,
      REQ_REPEAT   = 2'd2,
      REQ_CANCEL   = 2'd3
   } stt_req_code_type;

   typedef enum logic [1:0] {
      ST_DONE   = 2'd0,
      ST_FIRED  = 2'd1,
      ST_ALLOC  = 2'd2,
      ST_REJECT = 2'd3
   } stt_status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_WALK,
      S_FINISH
   } stt_state_type;

   typedef struct packed {
      logic clr_active;
      logic alloc;
      logic load_time;
   } stt_wr_ctl_type;

   function automatic int unsigned slot_limit(input int unsigned n);
      return (n < MaxSlots) ? n : MaxSlots;
   endfunction

   function automatic int unsigned idx_bits(input int unsigned n);
      return (slot_limit(n) > 1) ? $clog2(slot_limit(n)) : 1;
   endfunction

endpackage

// File: hw/rtl/stt_if.sv
// Request and response channel interfaces for the slot timer table.
// Valid/ready handshake; no dependencies.
`timescale 1ns / 1ps

interface stt_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  req_type;
   logic [31:0] duration_ms;
   logic [3:0]  slot_index;
   logic [7:0]  event_tag;

   modport source (output valid, req_type, duration_ms, slot_index, event_tag, input ready);
   modport sink (input valid, req_type, duration_ms, slot_index, event_tag, output ready);
endinterface

interface stt_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] status;
   logic [3:0] result_slot;
   logic [7:0] result_tag;
   logic       last;

   modport source (output valid, status, result_slot, result_tag, last, input ready);
   modport sink (input valid, status, result_slot, result_tag, last, output ready);
endinterface

// File: hw/rtl/stt_slot_store.sv
// Timer slot table: active marks, repeat marks, remaining time, interval and tag.
// Depends on stt_pkg.
`timescale 1ns / 1ps

module stt_slot_store #(
   parameter int unsigned NUM_SLOTS = stt_pkg::NumSlotsDefault,
   parameter int unsigned TAG_BITS  = stt_pkg::TagBitsDefault,
   localparam int unsigned IDX_W    = stt_pkg::idx_bits(NUM_SLOTS)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  stt_pkg::stt_wr_ctl_type       wr_ctl,
   input  logic [IDX_W-1:0]              slot_addr,
   input  logic [stt_pkg::TIME_W-1:0]    wr_time,
   input  logic [stt_pkg::TIME_W-1:0]    wr_reload,
   input  logic                          wr_repeat,
   input  logic [TAG_BITS-1:0]           wr_tag,
   output logic                          rd_active,
   output logic                          rd_repeat,
   output logic [stt_pkg::TIME_W-1:0]    rd_time,
   output logic [stt_pkg::TIME_W-1:0]    rd_reload,
   output logic [TAG_BITS-1:0]           rd_tag
);
   import stt_pkg::*;

   localparam int unsigned LIMIT = slot_limit(NUM_SLOTS);

   logic [LIMIT-1:0]        active_ff;
   logic                    rep_ff    [LIMIT];
   logic [TIME_W-1:0]       time_ff   [LIMIT];
   logic [TIME_W-1:0]       reload_ff [LIMIT];
   logic [TAG_BITS-1:0]     tag_ff    [LIMIT];

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= '0;
      end else if (wr_ctl.alloc) begin
         active_ff[slot_addr] <= 1'b1;
      end else if (wr_ctl.clr_active) begin
         active_ff[slot_addr] <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_ctl.alloc) begin
         rep_ff[slot_addr]    <= wr_repeat;
         time_ff[slot_addr]   <= wr_time;
         reload_ff[slot_addr] <= wr_reload;
         tag_ff[slot_addr]    <= wr_tag;
      end else if (wr_ctl.load_time) begin
         time_ff[slot_addr]   <= wr_time;
      end
   end

   assign rd_active = active_ff[slot_addr];
   assign rd_repeat = rep_ff[slot_addr];
   assign rd_time   = time_ff[slot_addr];
   assign rd_reload = reload_ff[slot_addr];
   assign rd_tag    = tag_ff[slot_addr];

endmodule

// File: hw/rtl/stt_sequencer.sv
// Request sequencer: walks the table one slot per cycle unless stalled, via a shared
// saturating subtractor and holds the response register. Depends on stt_pkg, stt_if.
`timescale 1ns / 1ps

module stt_sequencer #(
   parameter int unsigned NUM_SLOTS = stt_pkg::NumSlotsDefault,
   parameter int unsigned TAG_BITS  = stt_pkg::TagBitsDefault,
   localparam int unsigned IDX_W    = stt_pkg::idx_bits(NUM_SLOTS)
) (
   input  logic                          clock,
   input  logic                          reset,
   stt_req_if.sink                       req_if,
   stt_rsp_if.source                     rsp_if,
   output stt_pkg::stt_wr_ctl_type       wr_ctl,
   output logic [IDX_W-1:0]              slot_addr,
   output logic [stt_pkg::TIME_W-1:0]    wr_time,
   output logic [stt_pkg::TIME_W-1:0]    wr_reload,
   output logic                          wr_repeat,
   output logic [TAG_BITS-1:0]           wr_tag,
   input  logic                          rd_active,
   input  logic                          rd_repeat,
   input  logic [stt_pkg::TIME_W-1:0]    rd_time,
   input  logic [stt_pkg::TIME_W-1:0]    rd_reload,
   input  logic [TAG_BITS-1:0]           rd_tag
);
   import stt_pkg::*;

   localparam int unsigned      LIMIT    = slot_limit(NUM_SLOTS);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(LIMIT - 1);
   localparam logic [4:0]       LIMIT_W  = 5'(LIMIT);

   stt_state_type       state_ff, state_in;
   stt_req_code_type    op_ff, op_in;
   logic [TIME_W-1:0]   dur_ff, dur_in;
   logic [TAG_BITS-1:0] tag_ff, tag_in;
   logic [IDX_W-1:0]    cnt_ff, cnt_in;
   stt_status_type      res_status_ff, res_status_in;
   logic [IDX_W-1:0]    res_slot_ff, res_slot_in;
   logic [TAG_BITS-1:0] res_tag_ff, res_tag_in;
   logic                out_valid_ff, out_valid_in;
   stt_status_type      out_status_ff, out_status_in;
   logic [3:0]          out_slot_ff, out_slot_in;
   logic [7:0]          out_tag_ff, out_tag_in;
   logic                out_last_ff, out_last_in;

   logic [TIME_W:0] diff;
   logic            fired;
   logic            out_free;

   assign diff     = {1'b0, rd_time} - {1'b0, dur_ff};
   assign fired    = rd_active && (diff[TIME_W] || (diff[TIME_W-1:0] == '0));
   assign out_free = !out_valid_ff || rsp_if.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      dur_ff        <= dur_in;
      tag_ff        <= tag_in;
      cnt_ff        <= cnt_in;
      res_status_ff <= res_status_in;
      res_slot_ff   <= res_slot_in;
      res_tag_ff    <= res_tag_in;
      out_status_ff <= out_status_in;
      out_slot_ff   <= out_slot_in;
      out_tag_ff    <= out_tag_in;
      out_last_ff   <= out_last_in;
   end

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      dur_in        = dur_ff;
      tag_in        = tag_ff;
      cnt_in        = cnt_ff;
      res_status_in = res_status_ff;
      res_slot_in   = res_slot_ff;
      res_tag_in    = res_tag_ff;
      out_valid_in  = out_valid_ff && !rsp_if.ready;
      out_status_in = out_status_ff;
      out_slot_in   = out_slot_ff;
      out_tag_in    = out_tag_ff;
      out_last_in   = out_last_ff;
      wr_ctl        = '0;
      slot_addr     = cnt_ff;
      wr_time       = dur_ff;
      wr_reload     = '0;
      wr_repeat     = 1'b0;
      wr_tag        = tag_ff;
      req_if.ready  = (state_ff == S_IDLE);

      case (state_ff)
         S_IDLE: begin
            if (req_if.valid) begin
               op_in         = stt_req_code_type'(req_if.req_type);
               dur_in        = req_if.duration_ms;
               tag_in        = TAG_BITS'(req_if.event_tag);
               cnt_in        = '0;
               res_status_in = ST_DONE;
               res_slot_in   = '0;
               res_tag_in    = '0;
               state_in      = S_FINISH;
               case (stt_req_code_type'(req_if.req_type))
                  REQ_TICK: begin
                     if (req_if.duration_ms != '0) state_in = S_WALK;
                  end
                  REQ_ONE_SHOT: begin
                     res_status_in = ST_REJECT;
                     state_in      = S_WALK;
                  end
                  REQ_REPEAT: begin
                     res_status_in = ST_REJECT;
                     if (req_if.duration_ms != '0) state_in = S_WALK;
                  end
                  REQ_CANCEL: begin
                     slot_addr = req_if.slot_index[IDX_W-1:0];
                     if ({1'b0, req_if.slot_index} < LIMIT_W) wr_ctl.clr_active = 1'b1;
                  end
                  default: begin
                     state_in = S_FINISH;
                  end
               endcase
            end
         end

         S_WALK: begin
            if (op_ff == REQ_TICK) begin
               if (fired && res_status_ff == ST_FIRED && !out_free) begin
                  // hold: previous firing still waits for the response register
                  state_in = S_WALK;
               end else begin
                  if (fired) begin
                     if (res_status_ff == ST_FIRED) begin
                        out_valid_in  = 1'b1;
                        out_status_in = ST_FIRED;
                        out_slot_in   = 4'(res_slot_ff);
                        out_tag_in    = 8'(res_tag_ff);
                        out_last_in   = 1'b0;
                     end
                     res_status_in = ST_FIRED;
                     res_slot_in   = cnt_ff;
                     res_tag_in    = rd_tag;
                     if (rd_repeat) begin
                        wr_ctl.load_time = 1'b1;
                        wr_time          = rd_reload;
                     end else begin
                        wr_ctl.clr_active = 1'b1;
                     end
                  end else if (rd_active) begin
                     wr_ctl.load_time = 1'b1;
                     wr_time          = diff[TIME_W-1:0];
                  end
                  if (cnt_ff == LAST_IDX) state_in = S_FINISH;
                  else cnt_in = cnt_ff + 1'b1;
               end
            end else begin
               if (!rd_active) begin
                  wr_ctl.alloc  = 1'b1;
                  wr_time       = dur_ff;
                  wr_reload     = (op_ff == REQ_REPEAT) ? dur_ff : '0;
                  wr_repeat     = (op_ff == REQ_REPEAT);
                  wr_tag        = tag_ff;
                  res_status_in = ST_ALLOC;
                  res_slot_in   = cnt_ff;
                  state_in      = S_FINISH;
               end else if (cnt_ff == LAST_IDX) begin
                  state_in = S_FINISH;
               end else begin
                  cnt_in = cnt_ff + 1'b1;
               end
            end
         end

         S_FINISH: begin
            if (out_free) begin
               out_valid_in  = 1'b1;
               out_status_in = res_status_ff;
               out_slot_in   = 4'(res_slot_ff);
               out_tag_in    = 8'(res_tag_ff);
               out_last_in   = 1'b1;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_if.valid       = out_valid_ff;
   assign rsp_if.status      = out_status_ff;
   assign rsp_if.result_slot = out_slot_ff;
   assign rsp_if.result_tag  = out_tag_ff;
   assign rsp_if.last        = out_last_ff;

endmodule

// File: hw/rtl/slot_timer_table.sv
// Slot timer table top level: sequencer plus slot store.
// Depends on stt_pkg, stt_if, stt_slot_store, stt_sequencer and the assertion macros.
//
// A table of up to sixteen one-shot or repeating timer slots. Requests go through one
// saturating subtract/compare unit that walks the table one slot per cycle while no
// firing waits for the response register. A cancel, a zero tick or a repeating request
// with a zero interval goes straight to its result. A tick walks all N slots of the
// table (at most sixteen), whether in use or not. A schedule walks up to the lowest
// free slot, or the whole table when it is full. Any request is held up while a
// firing or its final result waits for the response register to drain. Results leave
// through a response register, so a request is taken while the last result of the
// previous one still waits. The table comes out of reset empty.
`timescale 1ns / 1ps
`include "slot_timer_table_defines.svh"

module slot_timer_table #(
   parameter int unsigned NUM_SLOTS = stt_pkg::NumSlotsDefault,
   parameter int unsigned TAG_BITS  = stt_pkg::TagBitsDefault
) (
   input  logic      clock,
   input  logic      reset,
   stt_req_if.sink   req_if,
   stt_rsp_if.source rsp_if
);
   import stt_pkg::*;

   localparam int unsigned IDX_W = idx_bits(NUM_SLOTS);

   stt_wr_ctl_type      wr_ctl;
   logic [IDX_W-1:0]    slot_addr;
   logic [TIME_W-1:0]   wr_time;
   logic [TIME_W-1:0]   wr_reload;
   logic                wr_repeat;
   logic [TAG_BITS-1:0] wr_tag;
   logic                rd_active;
   logic                rd_repeat;
   logic [TIME_W-1:0]   rd_time;
   logic [TIME_W-1:0]   rd_reload;
   logic [TAG_BITS-1:0] rd_tag;

   stt_slot_store #(
      .NUM_SLOTS (NUM_SLOTS),
      .TAG_BITS  (TAG_BITS)
   ) u_store (
      .clock     (clock),
      .reset     (reset),
      .wr_ctl    (wr_ctl),
      .slot_addr (slot_addr),
      .wr_time   (wr_time),
      .wr_reload (wr_reload),
      .wr_repeat (wr_repeat),
      .wr_tag    (wr_tag),
      .rd_active (rd_active),
      .rd_repeat (rd_repeat),
      .rd_time   (rd_time),
      .rd_reload (rd_reload),
      .rd_tag    (rd_tag)
   );

   stt_sequencer #(
      .NUM_SLOTS (NUM_SLOTS),
      .TAG_BITS  (TAG_BITS)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .rsp_if    (rsp_if),
      .wr_ctl    (wr_ctl),
      .slot_addr (slot_addr),
      .wr_time   (wr_time),
      .wr_reload (wr_reload),
      .wr_repeat (wr_repeat),
      .wr_tag    (wr_tag),
      .rd_active (rd_active),
      .rd_repeat (rd_repeat),
      .rd_time   (rd_time),
      .rd_reload (rd_reload),
      .rd_tag    (rd_tag)
   );

   `STT_ASSERT_NEXT(a_busy_after_request, req_if.valid && req_if.ready, !req_if.ready, "ready high right after a request")
   `STT_ASSERT_IMPLIES(a_single_result_last, rsp_if.valid && (rsp_if.status != ST_FIRED), rsp_if.last, "non-fire result without last")
   `STT_ASSERT_IMPLIES(a_empty_fields_zero, rsp_if.valid && ((rsp_if.status == ST_DONE) || (rsp_if.status == ST_REJECT)), (rsp_if.result_slot == '0) && (rsp_if.result_tag == '0), "done or reject result with nonzero fields")
   `STT_ASSERT_ALWAYS(a_one_table_write, $onehot0(wr_ctl), "more than one slot write kind at once")

endmodule

// File: tb/tb_slot_timer_table.sv
// Self-checking testbench for slot_timer_table: directed and random timer requests.
// A scoreboard class predicts every response; depends on stt_pkg, stt_if and the RTL.
`timescale 1ns / 1ps

module tb_slot_timer_table;
   import stt_pkg::*;

   localparam int unsigned TABLE_SLOTS    = 16;
   localparam int unsigned WATCHDOG_LIMIT = 2000;
   localparam int unsigned RANDOM_PER_PHASE = 45;

   typedef struct packed {
      stt_status_type status;
      logic [3:0]     slot;
      logic [7:0]     tag;
      logic           last;
   } timer_response_type;

   class timer_table_scoreboard;
      bit                 active[TABLE_SLOTS];
      bit                 periodic[TABLE_SLOTS];
      bit [31:0]          remaining[TABLE_SLOTS];
      bit [31:0]          interval[TABLE_SLOTS];
      bit [7:0]           slot_tag[TABLE_SLOTS];
      timer_response_type expected_q[$];
      int unsigned        error_count;

      function void expect_response(stt_status_type st, logic [3:0] slot, logic [7:0] tag,
                                    logic last);
         timer_response_type r;
         r.status = st;
         r.slot   = slot;
         r.tag    = tag;
         r.last   = last;
         expected_q.push_back(r);
      endfunction

      function void note_request(stt_req_code_type code, logic [31:0] dur, logic [3:0] idx,
                                 logic [7:0] ev_tag);
         int fired;
         int free_slot;
         fired     = 0;
         free_slot = -1;
         case (code)
            REQ_TICK: begin
               if (dur != 0) begin
                  for (int s = 0; s < TABLE_SLOTS; s++) begin
                     if (active[s]) begin
                        remaining[s] = (dur >= remaining[s]) ? 32'd0 : remaining[s] - dur;
                        if (remaining[s] == 0) begin
                           expect_response(ST_FIRED, s[3:0], slot_tag[s], 1'b0);
                           fired++;
                           if (periodic[s]) remaining[s] = interval[s];
                           else active[s] = 1'b0;
                        end
                     end
                  end
               end
               if (fired == 0) expect_response(ST_DONE, 4'd0, 8'd0, 1'b1);
               else expected_q[expected_q.size() - 1].last = 1'b1;
            end
            REQ_ONE_SHOT, REQ_REPEAT: begin
               if (code == REQ_REPEAT && dur == 0) begin
                  expect_response(ST_REJECT, 4'd0, 8'd0, 1'b1);
               end else begin
                  for (int s = TABLE_SLOTS - 1; s >= 0; s--)
                     if (!active[s]) free_slot = s;
                  if (free_slot < 0) begin
                     expect_response(ST_REJECT, 4'd0, 8'd0, 1'b1);
                  end else begin
                     active[free_slot]    = 1'b1;
                     periodic[free_slot]  = (code == REQ_REPEAT);
                     remaining[free_slot] = dur;
                     interval[free_slot]  = (code == REQ_REPEAT) ? dur : 32'd0;
                     slot_tag[free_slot]  = ev_tag;
                     expect_response(ST_ALLOC, free_slot[3:0], 8'd0, 1'b1);
                  end
               end
            end
            default: begin
               active[idx] = 1'b0;
               expect_response(ST_DONE, 4'd0, 8'd0, 1'b1);
            end
         endcase
      endfunction

      function void check_response(logic [1:0] st, logic [3:0] slot, logic [7:0] tag,
                                   logic last);
         timer_response_type exp_rsp;
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected response status=%0d slot=%0d tag=%0h last=%0b",
                     $time, st, slot, tag, last);
            error_count++;
            return;
         end
         exp_rsp = expected_q.pop_front();
         if (st !== exp_rsp.status) begin
            $display("%0t: status expected %0d actual %0d", $time, exp_rsp.status, st);
            error_count++;
         end
         if (slot !== exp_rsp.slot) begin
            $display("%0t: result_slot expected %0d actual %0d", $time, exp_rsp.slot, slot);
            error_count++;
         end
         if (tag !== exp_rsp.tag) begin
            $display("%0t: result_tag expected %0h actual %0h", $time, exp_rsp.tag, tag);
            error_count++;
         end
         if (last !== exp_rsp.last) begin
            $display("%0t: last expected %0b actual %0b", $time, exp_rsp.last, last);
            error_count++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   int unsigned send_idle_pct;
   int unsigned recv_idle_pct;
   int unsigned quiet_cycles;
   timer_table_scoreboard sb;

   stt_req_if req_ch ();
   stt_rsp_if rsp_ch ();

   slot_timer_table i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(negedge clock) begin
      rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
         sb.check_response(rsp_ch.status, rsp_ch.result_slot, rsp_ch.result_tag, rsp_ch.last);
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
          (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: watchdog expired", $time);
         $display("FAILURE");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_request(input stt_req_code_type code, input logic [31:0] dur,
                               input logic [3:0] idx, input logic [7:0] ev_tag);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.req_type    <= code;
      req_ch.duration_ms <= dur;
      req_ch.slot_index  <= idx;
      req_ch.event_tag   <= ev_tag;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      sb.note_request(code, dur, idx, ev_tag);
   endtask

   task automatic send_random_request();
      stt_req_code_type code;
      logic [31:0]      dur;
      int unsigned      pick;
      int unsigned      sel;
      pick = $urandom_range(99);
      sel  = $urandom_range(99);
      if (pick < 35) code = REQ_TICK;
      else if (pick < 60) code = REQ_ONE_SHOT;
      else if (pick < 80) code = REQ_REPEAT;
      else code = REQ_CANCEL;
      if (sel < 5) dur = 32'd0;
      else if (sel < 9) dur = $urandom;
      else if (code == REQ_TICK) dur = $urandom_range(12, 1);
      else dur = $urandom_range(40, 1);
      send_request(code, dur, 4'($urandom_range(15)), 8'($urandom_range(255)));
   endtask

   task automatic wait_for_drain();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (sb.expected_q.size() != 0) @(negedge clock);
   endtask

   initial begin
      sb                 = new();
      send_idle_pct      = 9;
      recv_idle_pct      = 79;
      quiet_cycles       = 0;
      reset              = 1'b1;
      req_ch.valid       = 1'b0;
      req_ch.req_type    = REQ_TICK;
      req_ch.duration_ms = 32'd0;
      req_ch.slot_index  = 4'd0;
      req_ch.event_tag   = 8'd0;
      rsp_ch.ready       = 1'b0;
      repeat (11) @(negedge clock);
      reset <= 1'b0;

      send_request(REQ_TICK, 32'd0, 4'd0, 8'd0);
      send_request(REQ_CANCEL, 32'd0, 4'd5, 8'd0);
      send_request(REQ_REPEAT, 32'd0, 4'd0, 8'h3C);
      send_request(REQ_ONE_SHOT, 32'd0, 4'd0, 8'hFF);
      send_request(REQ_REPEAT, 32'd1, 4'd0, 8'h00);
      send_request(REQ_REPEAT, 32'hFFFF_FFFF, 4'd0, 8'hA5);
      send_request(REQ_ONE_SHOT, 32'hFFFF_FFFF, 4'hF, 8'h5A);
      for (int n = 4; n < TABLE_SLOTS; n++)
         send_request(REQ_ONE_SHOT, $urandom_range(200, 2), 4'd0, 8'($urandom_range(255)));
      send_request(REQ_ONE_SHOT, 32'd7, 4'd0, 8'h11);
      send_request(REQ_TICK, 32'd0, 4'd0, 8'd0);
      send_request(REQ_TICK, 32'd1, 4'd0, 8'd0);
      send_request(REQ_TICK, 32'hFFFF_FFFF, 4'd0, 8'd0);
      send_request(REQ_CANCEL, 32'd0, 4'd15, 8'd0);
      send_request(REQ_CANCEL, 32'hFFFF_FFFF, 4'd1, 8'hFF);

      for (int phase = 0; phase < 3; phase++) begin
         wait_for_drain();
         send_idle_pct = (phase == 0) ? 9 : (phase == 1) ? 79 : 0;
         recv_idle_pct = (phase == 0) ? 79 : (phase == 1) ? 9 : 0;
         repeat (RANDOM_PER_PHASE) send_random_request();
      end

      wait_for_drain();
      repeat (40) @(posedge clock);
      if (sb.error_count == 0 && sb.expected_q.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/stt_pkg.sv
hw/rtl/stt_if.sv
hw/rtl/stt_slot_store.sv
hw/rtl/stt_sequencer.sv
hw/rtl/slot_timer_table.sv
tb/tb_slot_timer_table.sv
